FILE: hdl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, constants and helpers for the remote serial packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

	localparam int BUFFER_BYTES = 512;
	localparam int LEN_W = 9;
	localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(BUFFER_BYTES - 1);
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 9'd511;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END = 8'h23;
	localparam logic [7:0] CH_ACK = 8'h2B;
	localparam logic [7:0] CH_NAK = 8'h2D;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_GOOD = 2'd1;
	localparam logic [1:0] KIND_BAD = 2'd2;

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_DATA = 4'b0010,
		PH_HI = 4'b0100,
		PH_LO = 4'b1000
	} rpd_phase_t;

	typedef struct packed {
		logic has;
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [LEN_W-1:0] payload_len;
		logic [7:0] reply_char;
		logic link_seen;
	} rpd_res_t;

	// Returns {invalid, value} for one hex digit of either case.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b10000;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b0, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b0, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: hdl/rpd_engine.sv
// ----------------------------------------------------------------------------
// rpd_engine
// Framing state machine: decides the result for the byte in the input stage
// and updates the packet state when that byte moves on.
// ----------------------------------------------------------------------------
module rpd_engine
	import rpd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] byte_in,
	input logic [LEN_W-1:0] limit,
	output rpd_res_t res
);

	rpd_phase_t phase_q, phase_d;
	logic [7:0] sum_q, sum_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [3:0] hi_q, hi_d;
	logic err_q, err_d;
	logic conn_q, conn_d;
	logic [4:0] hex;
	logic good;

	assign hex = hex_decode(byte_in);
	assign good = !err_q && !hex[4] && ({hi_q, hex[3:0]} == sum_q);

	always_comb begin
		phase_d = phase_q;
		sum_d = sum_q;
		count_d = count_q;
		hi_d = hi_q;
		err_d = err_q;
		conn_d = conn_q;
		res = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_in == CH_START) begin
					phase_d = PH_DATA;
					sum_d = '0;
					count_d = '0;
					hi_d = '0;
					err_d = 1'b0;
				end
			end
			PH_DATA: begin
				if (byte_in == CH_END) begin
					phase_d = PH_HI;
				end else if (count_q < limit) begin
					count_d = count_q + 1'b1;
					sum_d = sum_q + byte_in;
					res.has = 1'b1;
					res.kind = KIND_DATA;
					res.data_byte = byte_in;
					res.link_seen = conn_q;
				end
			end
			PH_HI: begin
				err_d = hex[4];
				hi_d = hex[4] ? 4'd0 : hex[3:0];
				phase_d = PH_LO;
			end
			PH_LO: begin
				conn_d = conn_q | good;
				phase_d = PH_HUNT;
				res.has = 1'b1;
				res.kind = good ? KIND_GOOD : KIND_BAD;
				res.payload_len = count_q;
				res.reply_char = good ? CH_ACK : CH_NAK;
				res.link_seen = conn_q | good;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q <= '0;
			count_q <= '0;
			hi_q <= '0;
			err_q <= 1'b0;
			conn_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q <= sum_d;
			count_q <= count_d;
			hi_q <= hi_d;
			err_q <= err_d;
			conn_q <= conn_d;
		end
	end

endmodule

FILE: hdl/rsp_packet_deframer.sv
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// Receives serial bytes, strips packet framing, checks the two-digit hex
// checksum and reports payload bytes and packet end status.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// rx        rx_valid / rx_ready    rx_byte
// res       res_valid / res_ready  kind, data_byte, payload_len, reply_char,
//                                  link_seen
// cfg       cfg_we                 cfg_data (max_payload)
//
// One byte is accepted per cycle unless a stalled result holds the input
// register. A byte passes an input register and then a result register.
// A stalled result holds the result register while the input register can
// still take one more byte. Reset returns to hunting for a start mark and
// sets max_payload to 511.
// ----------------------------------------------------------------------------
module rsp_packet_deframer
	import rpd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	output logic rx_ready,
	input logic [7:0] rx_byte,
	output logic res_valid,
	input logic res_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [LEN_W-1:0] payload_len,
	output logic [7:0] reply_char,
	output logic link_seen,
	input logic cfg_we,
	input logic [LEN_W-1:0] cfg_data
);

	logic [LEN_W-1:0] max_payload_q;
	logic [LEN_W-1:0] limit;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic res_valid_q;
	rpd_res_t res_q;
	rpd_res_t res;
	logic out_free;
	logic move;
	logic load;

	assign limit = (max_payload_q < LIMIT_CAP) ? max_payload_q : LIMIT_CAP;
	assign out_free = !res_valid_q || res_ready;
	assign move = valid_s1 && (!res.has || out_free);
	assign load = move && res.has;
	assign rx_ready = !valid_s1 || move;

	rpd_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.step(move),
		.byte_in(byte_s1),
		.limit(limit),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else if (load) begin
			res_valid_q <= 1'b1;
			res_q <= res;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign kind = res_q.kind;
	assign data_byte = res_q.data_byte;
	assign payload_len = res_q.payload_len;
	assign reply_char = res_q.reply_char;
	assign link_seen = res_q.link_seen;

endmodule

FILE: hdl/rpd_checker.sv
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks for the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module rpd_checker
	import rpd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic [7:0] reply_char,
	input logic link_seen
);

	a_reply_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (kind == KIND_DATA && reply_char == 8'd0) ||
			(kind == KIND_GOOD && reply_char == CH_ACK) ||
			(kind == KIND_BAD && reply_char == CH_NAK))
		else $error("reply character does not match result kind");

	a_end_has_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_DATA |-> data_byte == 8'd0)
		else $error("packet end carries a data byte");

	a_good_sets_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_GOOD |-> link_seen)
		else $error("good packet without link flag");

	a_link_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		link_seen |=> link_seen)
		else $error("link flag dropped");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(data_byte))
		else $error("stalled result changed");

endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.kind(kind),
	.data_byte(data_byte),
	.reply_char(reply_char),
	.link_seen(link_seen)
);
